// ===== hdl/octn_pkg.sv =====
// shared types and constants for the octree neighbour enumerator
`timescale 1ns / 1ps

package octn_pkg;

   localparam int LVL_W = 5;    // tree level field
   localparam int IDX_W = 63;   // morton index field
   localparam int POS_W = 5;    // ordinal of a result in its list
   localparam int AXES  = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } octn_state_type;

   typedef struct packed {
      logic load;   // latch clamped ranges, start at the low corner
      logic step;   // move to the next box, z fastest
   } walk_ctrl_type;

endpackage

// ===== hdl/octn_walker.sv =====
// range walker: clamps the three axis ranges and steps through them with one incrementer
`timescale 1ns / 1ps

module octn_walker #(
   parameter int COORD_BITS = 21
) (
   input  logic                                         clock,
   input  octn_pkg::walk_ctrl_type                      walk_ctrl,
   input  logic [octn_pkg::AXES-1:0][COORD_BITS-1:0]    center,
   input  logic [COORD_BITS-1:0]                        grid_top,
   output logic [octn_pkg::AXES-1:0][COORD_BITS-1:0]    cur,
   output logic                                         at_end
);
   import octn_pkg::*;

   logic [AXES-1:0][COORD_BITS-1:0] lo_ff, lo_in;
   logic [AXES-1:0][COORD_BITS-1:0] hi_ff, hi_in;
   logic [AXES-1:0][COORD_BITS-1:0] cur_ff, cur_in;
   logic [AXES-1:0]                 at_hi;
   logic [1:0]                      sel;
   logic [COORD_BITS-1:0]           inc_val;

   // clamp center-1 .. center+1 to the grid
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         lo_in[a] = (center[a] != '0) ? center[a] - COORD_BITS'(1) : '0;
         hi_in[a] = (center[a] != grid_top) ? center[a] + COORD_BITS'(1) : grid_top;
         at_hi[a] = (cur_ff[a] == hi_ff[a]);
      end
   end

   // innermost axis that has not reached its top gets the increment
   always_comb begin
      priority if (!at_hi[2]) begin
         sel = 2'd2;
      end else if (!at_hi[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd0;
      end
   end

   assign inc_val = cur_ff[sel] + COORD_BITS'(1);

   always_comb begin
      cur_in = cur_ff;
      if (walk_ctrl.load) begin
         cur_in = lo_in;
      end else if (walk_ctrl.step) begin
         for (int a = 0; a < AXES; a++) begin
            if (2'(a) == sel) begin
               cur_in[a] = inc_val;
            end else if (2'(a) > sel) begin
               cur_in[a] = lo_ff[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (walk_ctrl.load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign cur    = cur_ff;
   assign at_end = &at_hi;

endmodule

// ===== hdl/octree_neighbour_enumerator.sv =====
// top level: decodes the box, walks its clamped neighbourhood, registers each result
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   request | req_valid req_ready req_tree_level         | in
//           | req_box_index                              |
//   result  | rsp_valid rsp_ready rsp_neighbour_index    | out
//           | rsp_position rsp_last                      |
//
// a request goes through accept, a setup state that checks the index against the level
// and clamps the ranges, then the walk, one result per cycle while the output slot is free.
// an index outside its level gives no result and frees the block after the setup state.
// the walk waits while the output register is full and rsp_ready is low.
// reset is synchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps

module octree_neighbour_enumerator #(
   parameter int COORD_BITS = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [octn_pkg::LVL_W-1:0]    req_tree_level,
   input  logic [octn_pkg::IDX_W-1:0]    req_box_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [octn_pkg::IDX_W-1:0]    rsp_neighbour_index,
   output logic [octn_pkg::POS_W-1:0]    rsp_position,
   output logic                          rsp_last
);
   import octn_pkg::*;

   localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(COORD_BITS);

   octn_state_type state_ff, state_in;

   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [LVL_W+1:0]                lvl3;
   logic                            out_of_level;
   logic [COORD_BITS-1:0]           grid_top;
   logic [AXES-1:0][COORD_BITS-1:0] center;
   logic [AXES-1:0][COORD_BITS-1:0] cur;
   logic                            at_end;
   logic [IDX_W-1:0]                nbr_index;
   logic                            slot_free;
   logic                            emit;
   walk_ctrl_type                   walk_ctrl;

   // box decode: coordinates, grid top, any index bit at or above 3*level
   assign lvl3 = (LVL_W + 2)'(lvl_ff) * (LVL_W + 2)'(3);

   always_comb begin
      out_of_level = 1'b0;
      for (int p = 0; p < IDX_W; p++) begin
         if (idx_ff[p] && ((LVL_W + 2)'(p) >= lvl3)) begin
            out_of_level = 1'b1;
         end
      end
      for (int b = 0; b < COORD_BITS; b++) begin
         grid_top[b] = (LVL_W'(b) < lvl_ff);
         for (int a = 0; a < AXES; a++) begin
            center[a][b] = idx_ff[AXES * b + a];
         end
      end
   end

   // re-interleave the walker's current box
   always_comb begin
      nbr_index = '0;
      for (int b = 0; b < COORD_BITS; b++) begin
         for (int a = 0; a < AXES; a++) begin
            nbr_index[AXES * b + a] = cur[a][b];
         end
      end
   end

   octn_walker #(
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock     (clock),
      .walk_ctrl (walk_ctrl),
      .center    (center),
      .grid_top  (grid_top),
      .cur       (cur),
      .at_end    (at_end)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = out_of_level ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            if (slot_free && at_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      walk_ctrl.load = 1'b0;
      walk_ctrl.step = 1'b0;
      emit           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SETUP: begin
            walk_ctrl.load = !out_of_level;
         end
         ST_RUN: begin
            emit           = slot_free;
            walk_ctrl.step = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // request capture, level saturates at the coordinate width
   always_comb begin
      lvl_in = lvl_ff;
      idx_in = idx_ff;
      if (req_valid && req_ready) begin
         lvl_in = (req_tree_level > MAX_LVL) ? MAX_LVL : req_tree_level;
         idx_in = req_box_index;
      end
   end

   // output register
   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (walk_ctrl.load) begin
         pos_in = '0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = nbr_index;
         rsp_pos_in   = pos_ff;
         rsp_last_in  = at_end;
         pos_in       = pos_ff + POS_W'(1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff       <= lvl_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbour_index = rsp_index_ff;
   assign rsp_position        = rsp_pos_ff;
   assign rsp_last            = rsp_last_ff;

`ifndef SYNTHESIS
   // the final result of a walk frees the block for the next request
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (emit && at_end) |=> req_ready)
      else $error("walk did not return to idle after its final result");

   // a neighbourhood holds at most 27 boxes
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= POS_W'(26)))
      else $error("result position beyond the 3x3x3 neighbourhood");

   // the walk starts at ordinal zero
   a_first_pos: assert property (@(posedge clock) disable iff (reset)
      walk_ctrl.load |=> (pos_ff == '0))
      else $error("position counter not cleared at walk start");

   // an out-of-level box produces nothing
   a_bad_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP && out_of_level) |=> (state_ff == ST_IDLE && !emit))
      else $error("out-of-level box started a walk");
`endif

endmodule

// ===== tb/sv/octn_neighbour_checker.sv =====
// checker for the octree neighbour enumerator: predicts each request's neighbour list and compares
`timescale 1ns / 1ps

module octn_neighbour_checker #(
   parameter int COORD_BITS = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [octn_pkg::LVL_W-1:0]    req_tree_level,
   input  logic [octn_pkg::IDX_W-1:0]    req_box_index,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [octn_pkg::IDX_W-1:0]    rsp_neighbour_index,
   input  logic [octn_pkg::POS_W-1:0]    rsp_position,
   input  logic                          rsp_last,
   output int                            error_count,
   output int                            pending_count
);

   import octn_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [POS_W-1:0] position;
      logic             last;
   } neighbour_type;

   neighbour_type expected_neighbours[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // every box in the clamped 3x3x3 block around the request's box, x slowest, z fastest
   task automatic predict_neighbours(input logic [LVL_W-1:0] level,
                                     input logic [IDX_W-1:0] box);
      int               lvl;
      int               top;
      int               count;
      int               n;
      int               coord[AXES];
      int               lo[AXES];
      int               hi[AXES];
      logic [IDX_W-1:0] morton;
      neighbour_type    item;
      lvl = (level > COORD_BITS) ? COORD_BITS : int'(level);
      // any bit at or above 3*level puts the box off the grid
      if (({1'b0, box} >> (3 * lvl)) != 64'd0) return;
      top = (1 << lvl) - 1;
      for (int a = 0; a < AXES; a++) begin
         coord[a] = 0;
         for (int b = 0; b < COORD_BITS; b++) coord[a][b] = box[3 * b + a];
         lo[a] = (coord[a] > 0) ? coord[a] - 1 : 0;
         hi[a] = (coord[a] < top) ? coord[a] + 1 : top;
      end
      count = (hi[0] - lo[0] + 1) * (hi[1] - lo[1] + 1) * (hi[2] - lo[2] + 1);
      n = 0;
      for (int x = lo[0]; x <= hi[0]; x++) begin
         for (int y = lo[1]; y <= hi[1]; y++) begin
            for (int z = lo[2]; z <= hi[2]; z++) begin
               morton = '0;
               for (int b = 0; b < COORD_BITS; b++) begin
                  morton[3 * b]     = x[b];
                  morton[3 * b + 1] = y[b];
                  morton[3 * b + 2] = z[b];
               end
               item.index    = morton;
               item.position = POS_W'(n);
               item.last     = (n == count - 1);
               expected_neighbours.push_back(item);
               n++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      neighbour_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_neighbours(req_tree_level, req_box_index);
         if (rsp_valid && rsp_ready) begin
            if (expected_neighbours.size() == 0) begin
               $display("%0t: result with no request behind it: index %h position %0d last %b",
                        $time, rsp_neighbour_index, rsp_position, rsp_last);
               error_count++;
            end else begin
               want = expected_neighbours.pop_front();
               if (rsp_neighbour_index !== want.index) begin
                  $display("%0t: neighbour_index expected %h actual %h",
                           $time, want.index, rsp_neighbour_index);
                  error_count++;
               end
               if (rsp_position !== want.position) begin
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_position);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
      pending_count <= expected_neighbours.size();
   end

endmodule

// ===== tb/sv/octree_neighbour_enumerator_test.sv =====
// testbench top for the octree neighbour enumerator: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module octree_neighbour_enumerator_test;

   import octn_pkg::*;

   localparam int COORD_BITS       = 21;
   localparam int RANDOM_REQUESTS  = 420;
   // index bits that carry the x coordinate; y and z sit one and two places up
   localparam logic [IDX_W-1:0] X_BITS   = 63'h1249249249249249;
   localparam logic [IDX_W-1:0] ALL_ONES = {IDX_W{1'b1}};

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [LVL_W-1:0] req_tree_level = '0;
   logic [IDX_W-1:0] req_box_index  = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [IDX_W-1:0] rsp_neighbour_index;
   logic [POS_W-1:0] rsp_position;
   logic             rsp_last;
   logic             quiet          = 1'b0;
   int               error_count;
   int               pending_count;

   octree_neighbour_enumerator #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_tree_level      (req_tree_level),
      .req_box_index       (req_box_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_position        (rsp_position),
      .rsp_last            (rsp_last)
   );

   octn_neighbour_checker #(
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_tree_level      (req_tree_level),
      .req_box_index       (req_box_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_position        (rsp_position),
      .rsp_last            (rsp_last),
      .error_count         (error_count),
      .pending_count       (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 9);
      end
   end

   // present one request, maybe after a short gap, and hold it until taken
   task automatic send_request(input logic [LVL_W-1:0] level, input logic [IDX_W-1:0] box);
      if (!quiet && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_tree_level <= level;
      req_box_index  <= box;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int               pick;
      int               lvl;
      int               spot;
      logic [63:0]      wide;
      logic [LVL_W-1:0] level;
      logic [IDX_W-1:0] box;
      logic [IDX_W-1:0] in_level;
      logic [IDX_W-1:0] axis;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // level zero, boxes off the grid, corners, faces, edges, interior, saturated levels
      send_request(5'd0, '0);
      send_request(5'd0, 63'd1);
      send_request(5'd0, ALL_ONES);
      send_request(5'd1, '0);
      send_request(5'd1, 63'd7);
      send_request(5'd1, 63'd8);
      send_request(5'd2, 63'd7);
      send_request(5'd2, 63'd6);
      send_request(5'd2, 63'd4);
      send_request(5'd2, 63'd63);
      send_request(5'd2, X_BITS & 63'h3f);
      send_request(5'd3, 63'o525);
      send_request(5'd3, 63'o1000);
      send_request(5'd5, 63'd1 << 14);
      send_request(5'd5, 63'd1 << 15);
      send_request(5'd20, 63'd1 << 60);
      send_request(5'd20, ALL_ONES >> 3);
      send_request(5'd21, '0);
      send_request(5'd21, ALL_ONES);
      send_request(5'd21, X_BITS);
      send_request(5'd21, (X_BITS << 1) | (X_BITS << 2));
      send_request(5'd21, 63'h5a5a_5a5a_5a5a_5a5a);
      send_request(5'd22, ALL_ONES);
      send_request(5'd31, '0);
      send_request(5'd31, 63'd7);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // a long stretch where neither side idles
         quiet <= (n >= 150 && n < 230);
         pick = $urandom_range(0, 99);
         wide = {$urandom, $urandom};
         if (pick < 10) begin
            level = LVL_W'($urandom_range(0, 31));
            box   = wide[IDX_W-1:0];
         end else begin
            if (pick < 55) begin
               level = LVL_W'($urandom_range(0, 4));
            end else if (pick < 80) begin
               level = LVL_W'($urandom_range(5, 21));
            end else begin
               level = LVL_W'($urandom_range(22, 31));
            end
            lvl      = (level > COORD_BITS) ? COORD_BITS : int'(level);
            in_level = ALL_ONES >> (IDX_W - 3 * lvl);
            box      = wide[IDX_W-1:0] & in_level;
            // push some axes onto the low or high face of the grid
            for (int a = 0; a < AXES; a++) begin
               axis = X_BITS << a;
               case ($urandom_range(0, 3))
                  0: box = box & ~axis;
                  1: box = box | (axis & in_level);
                  default: ;
               endcase
            end
            if (lvl < COORD_BITS && $urandom_range(0, 9) == 0) begin
               spot      = $urandom_range(3 * lvl, IDX_W - 1);
               box[spot] = 1'b1;
            end
         end
         send_request(level, box);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("octree_neighbour_enumerator_test: done, clean");
      end else begin
         $display("octree_neighbour_enumerator_test: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("octree_neighbour_enumerator_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/octn_pkg.sv
hdl/octn_walker.sv
hdl/octree_neighbour_enumerator.sv
tb/sv/octn_neighbour_checker.sv
tb/sv/octree_neighbour_enumerator_test.sv
